// ===== rtl/dual_fan_tachometer_assert.svh =====
// Assertion macros for the dual fan tachometer.
// Used by files that check their own control logic; expects clk and arst_n in scope.
`ifndef DUAL_FAN_TACHOMETER_ASSERT_SVH
`define DUAL_FAN_TACHOMETER_ASSERT_SVH

// Clocked property, off while reset is asserted.
`define DFT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define DFT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/dft_pkg.sv =====
// Shared types and constants for the dual fan tachometer.
// No dependencies; imported by dft_lane and dual_fan_tachometer.
`timescale 1ns / 1ps

package dft_pkg;

	localparam int CNT_W    = 32;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int SPEED_W  = 16;
	localparam int DIV_STEPS = CNT_W;
	localparam int STEP_W   = $clog2(DIV_STEPS);

	// Configuration register indexes
	localparam logic REG_INTERVAL = 1'b0;
	localparam logic REG_SCALE    = 1'b1;

	localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd1000;
	localparam logic [CFG_W-1:0] SCALE_RST    = 16'd30000;

	// Controls from the sequencer to every lane
	typedef struct packed {
		logic count_en;   // item accepted: add its pulse
		logic start;      // load product, clear count
		logic div_step;   // one quotient bit
		logic last_step;  // final quotient bit: latch speed
	} lane_ctrl_t;

endpackage

// ===== rtl/dft_lane.sv =====
// One fan lane: pulse counter, scale multiply and bit-serial restoring divider.
// Depends on dft_pkg; driven by the sequencer in dual_fan_tachometer.
`timescale 1ns / 1ps

module dft_lane import dft_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic               pulse,
	input  logic [CFG_W-1:0]   scale,
	input  logic [TIME_W-1:0]  divisor,
	output logic [SPEED_W-1:0] speed
);

	logic [CNT_W-1:0]   count_q;
	logic [SPEED_W-1:0] rpm_q;
	logic [CNT_W-1:0]   quo_q;
	logic [TIME_W-1:0]  rem_q;

	logic [TIME_W:0]    rem_sh;
	logic [TIME_W:0]    rem_diff;
	logic               fits;
	logic [CNT_W-1:0]   quo_next;
	logic [TIME_W-1:0]  rem_next;
	logic [CNT_W-1:0]   product;

	// Count times scale, wrapped to the count width
	assign product = CNT_W'(count_q * {{(CNT_W-CFG_W){1'b0}}, scale});

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh   = {rem_q, quo_q[CNT_W-1]};
		rem_diff = rem_sh - {1'b0, divisor};
		fits     = (rem_sh >= {1'b0, divisor});
		rem_next = fits ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
		quo_next = {quo_q[CNT_W-2:0], fits};
	end

	// Pulse count and latest speed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rpm_q   <= '0;
		end else begin
			if (ctrl.count_en)
				count_q <= count_q + {{(CNT_W-1){1'b0}}, pulse};
			else if (ctrl.start)
				count_q <= '0;
			if (ctrl.last_step)
				rpm_q <= quo_next[SPEED_W-1:0];
		end
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q <= product;
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
	end

	assign speed = rpm_q;

endmodule

// ===== rtl/dual_fan_tachometer.sv =====
// Top level of the dual fan tachometer: stream ports, config registers,
// sequencer and two dft_lane instances. Depends on dft_pkg and the assert header.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata: two pulse flags and a
//   millisecond timestamp. Every item gives exactly one result item on
//   m_tvalid/m_tready/m_tdata/m_tuser: both speeds and an updated flag.
//   An item whose elapsed time is below the interval goes from accept
//   straight to the output state; one that recomputes passes accept, the
//   multiply state, 32 steps in each lane's bit-serial divider and output
//   load. The divider loop sets the rate; one item is in work at a time.
//   The output register holds a finished result while the next item is
//   accepted; if the receiver stalls, the sequencer waits in its output
//   state with s_tready low until the register frees.
//   Reset clears counts, speeds and the last timestamp and restores
//   interval_ms = 1000 and rpm_scale = 30000. Write configuration only
//   while idle: cfg_index 0 is interval_ms, 1 is rpm_scale.
`timescale 1ns / 1ps

`include "dual_fan_tachometer_assert.svh"

module dual_fan_tachometer import dft_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,   // fan1_pulse, fan2_pulse, now_ms[31:0], 6'b0
	// output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // fan1_speed[15:0], fan2_speed[15:0]
	output logic [0:0]       m_tuser    // updated
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [CFG_W-1:0]   interval_q;
	logic [CFG_W-1:0]   scale_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [TIME_W-1:0]  dt_q;
	logic               upd_q;
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;
	logic [0:0]         m_tuser_q;

	logic               accept;
	logic               fan1_pulse;
	logic               fan2_pulse;
	logic [TIME_W-1:0]  now_ms;
	logic [CFG_W-1:0]   limit;
	logic [TIME_W-1:0]  dt;
	logic               hit;
	logic               last;
	logic               out_free;
	lane_ctrl_t         ctrl;
	logic [SPEED_W-1:0] fan1_speed;
	logic [SPEED_W-1:0] fan2_speed;

	// Unpack input item
	assign fan1_pulse = s_tdata[0];
	assign fan2_pulse = s_tdata[1];
	assign now_ms     = s_tdata[33:2];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign last     = (step_q == STEP_W'(DIV_STEPS - 1));

	// Elapsed-time check; zero interval acts as one
	always_comb begin
		limit = (interval_q == '0) ? CFG_W'(1) : interval_q;
		dt    = now_ms - last_time_q;
		hit   = (dt >= {{(TIME_W-CFG_W){1'b0}}, limit});
	end

	// Lane controls
	always_comb begin
		ctrl.count_en  = accept;
		ctrl.start     = (state_q == ST_MUL);
		ctrl.div_step  = (state_q == ST_DIV);
		ctrl.last_step = (state_q == ST_DIV) && last;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			scale_q    <= SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL: interval_q <= cfg_data;
				REG_SCALE:    scale_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			last_time_q <= '0;
			upd_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						upd_q <= hit;
						if (hit) begin
							last_time_q <= now_ms;
							state_q     <= ST_MUL;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (last)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divisor for both lanes
	always_ff @(posedge clk) begin
		if (accept)
			dt_q <= dt;
	end

	// Two lanes, one per fan
	dft_lane u_lane1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.pulse   (fan1_pulse),
		.scale   (scale_q),
		.divisor (dt_q),
		.speed   (fan1_speed)
	);

	dft_lane u_lane2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.pulse   (fan2_pulse),
		.scale   (scale_q),
		.divisor (dt_q),
		.speed   (fan2_speed)
	);

	// Merge lane speeds into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if ((state_q == ST_OUT) && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata_q <= {fan2_speed, fan1_speed};
			m_tuser_q <= upd_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks
	`DFT_ASSERT(a_accept_leaves_idle, accept |=> state_q != ST_IDLE, "accept did not start work")
	`DFT_ASSERT(a_no_update_skips_div, accept && !hit |=> state_q == ST_OUT, "idle item entered divide")
	`DFT_ASSERT(a_div_ends, (state_q == ST_DIV) && last |=> state_q == ST_OUT, "divide overran")
	`DFT_ASSERT(a_time_kept, accept && hit |=> last_time_q == $past(now_ms), "timestamp not kept")
	`DFT_NEVER(a_ready_busy, s_tready && (state_q == ST_DIV || state_q == ST_MUL), "ready while busy")

endmodule
